>>> src/ordered_value_list_engine_assert.svh
// Assertion macros for the ordered value list engine.
`ifndef ORDERED_VALUE_LIST_ENGINE_ASSERT_SVH
`define ORDERED_VALUE_LIST_ENGINE_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define OVLE_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the condition.
`define OVLE_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ovle_pkg.sv
// Shared types and codes for the ordered value list engine.
`timescale 1ns / 1ps
`default_nettype none

package ovle_pkg;

   localparam int VALUE_W       = 32;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [OP_W-1:0]            op_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [ENTRY_COUNT_W-1:0]   entry_count_type;

   // Operation codes.
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;
   localparam op_type OP_MODIFY = 2'd3;

   // Status codes.
   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_NOMATCH = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

>>> src/ordered_value_list_engine.sv
// Ordered value list engine: a bounded newest-first list held in one memory.
//
// Usage: a transaction is accepted when start is high and busy is low; it
// carries an operation (insert, delete, search, modify), a key and a
// replacement value. Each transaction gives exactly one result, shown on the
// rsp_ ports for a single cycle while rsp_strobe is high; the receiver cannot
// stall, so results are simply presented and taken.
// The list is stored reversed in memory: the head sits at address count-1, so
// an insert is a single write and completes without raising busy; its result
// appears in the cycle after acceptance.
// Delete, search and modify walk the memory from the head, one read issued
// per cycle through the single read port, with the compare in the cycle after
// each read. A delete that hits at list position p then copies the p newer
// entries down one place, one copy per cycle on the write port.
// Reset empties the list at once; the memory itself is not cleared, since no
// entry above the count is ever read.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_value_list_engine_assert.svh"

module ordered_value_list_engine
   import ovle_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire op_type          req_operation,
   input  wire value_type       req_key_value,
   input  wire value_type       req_replacement,
   output logic                 rsp_strobe,
   output status_type           rsp_status,
   output entry_count_type      rsp_entry_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   // Control and payload registers.
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   op_type            op_ff, op_in;
   value_type         key_ff, key_in;
   value_type         repl_ff, repl_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              more_ff, more_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_addr_ff, cmp_addr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   entry_count_type   rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [VALUE_W-1:0] mem [CAPACITY];

   // Entry store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer: accept, walk from the head, then close the gap on delete.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      repl_in       = repl_ff;
      addr_in       = addr_ff;
      more_in       = more_ff;
      cmp_valid_in  = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = cmp_addr_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_operation;
               key_in  = req_key_value;
               repl_in = req_replacement;
               if (req_operation == OP_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  if (occ_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     // New head goes just above the current top of memory.
                     wr_en         = 1'b1;
                     wr_addr       = occ_ff[IDX_W-1:0];
                     wr_data       = req_key_value;
                     occ_in        = occ_ff + CNT_W'(1);
                     rsp_status_in = STATUS_DONE;
                  end
               end else if (occ_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NOMATCH;
               end else begin
                  state_in = ST_SCAN;
                  addr_in  = IDX_W'(occ_ff - CNT_W'(1));
                  more_in  = 1'b1;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next read, walking down from the head.
            if (more_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_addr_in  = addr_ff;
               if (addr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  addr_in = addr_ff - IDX_W'(1);
               end
            end
            // Compare the entry read in the previous cycle.
            if (cmp_valid_ff) begin
               if (rd_data_ff == key_ff) begin
                  case (op_ff)
                     OP_SEARCH: begin
                        state_in      = ST_IDLE;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_DONE;
                     end
                     OP_MODIFY: begin
                        wr_en         = 1'b1;
                        wr_addr       = cmp_addr_ff;
                        wr_data       = repl_ff;
                        state_in      = ST_IDLE;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_DONE;
                     end
                     default: begin
                        if (CNT_W'(cmp_addr_ff) + CNT_W'(1) == occ_ff) begin
                           // Match at the head: dropping the count is enough.
                           occ_in        = occ_ff - CNT_W'(1);
                           state_in      = ST_IDLE;
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = STATUS_DONE;
                        end else begin
                           state_in     = ST_SHIFT;
                           addr_in      = cmp_addr_ff + IDX_W'(1);
                           more_in      = 1'b1;
                           cmp_valid_in = 1'b0;
                        end
                     end
                  endcase
               end else if (cmp_addr_ff == '0) begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NOMATCH;
               end
            end
         end

         ST_SHIFT: begin
            // Read each newer entry and write it one address lower.
            if (more_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_addr_in  = addr_ff - IDX_W'(1);
               if (CNT_W'(addr_ff) + CNT_W'(1) == occ_ff) begin
                  more_in = 1'b0;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (cmp_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_addr_ff;
               wr_data = rd_data_ff;
               if (!more_ff) begin
                  occ_in        = occ_ff - CNT_W'(1);
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_DONE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The reported count is the one left after the transaction.
      if (rsp_strobe_in) begin
         rsp_count_in = ENTRY_COUNT_W'(occ_in);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         more_ff       <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         more_ff       <= more_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      repl_ff       <= repl_in;
      addr_ff       <= addr_in;
      cmp_addr_ff   <= cmp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Checks on the sequencer.
   `OVLE_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(CAPACITY), "count above capacity")
   `OVLE_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe_ff || busy, "accepted transaction neither answered nor in progress")
   `OVLE_ASSERT_SAME(a_shift_delete, clock, reset, state_ff == ST_SHIFT, op_ff == OP_DELETE, "gap closing outside a delete")
   `OVLE_ASSERT_SAME(a_full_count, clock, reset, rsp_strobe_ff && rsp_status_ff == STATUS_FULL, rsp_count_ff == ENTRY_COUNT_W'(CAPACITY), "full status with spare room")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the ordered value list engine.
`timescale 1ns / 1ps

module testbench;
   import ovle_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1200;
   localparam int SETTLE_TICKS = 40;

   // One list transaction as queued for the driver.
   typedef struct {
      op_type    operation;
      value_type key_value;
      value_type replacement;
      bit        drain_first;
   } list_request_type;

   // The result a transaction should produce.
   typedef struct {
      status_type      status;
      entry_count_type entry_count;
   } list_outcome_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   wire logic       busy;
   op_type          req_operation = OP_INSERT;
   value_type       req_key_value = '0;
   value_type       req_replacement = '0;
   wire logic       rsp_strobe;
   status_type      rsp_status;
   entry_count_type rsp_entry_count;

   list_request_type pending_requests[$];
   list_outcome_type awaited_outcomes[$];
   value_type        list_shadow[$];

   list_request_type current_request;
   list_outcome_type observed_expect;
   bit               presenting = 1'b0;
   bit               burst_mode = 1'b0;
   int               idle_left = 0;
   int               requests_accepted = 0;
   int               fail_count = 0;

   ordered_value_list_engine #(
      .CAPACITY(LIST_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key_value   (req_key_value),
      .req_replacement (req_replacement),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one accepted transaction to the shadow list and record its outcome.
   function automatic void predict_outcome(input list_request_type req);
      list_outcome_type outcome;
      int               hit;
      int               idx;
      hit = -1;
      outcome.status = STATUS_DONE;
      for (idx = 0; idx < list_shadow.size(); idx++) begin
         if (hit < 0 && list_shadow[idx] == req.key_value) begin
            hit = idx;
         end
      end
      case (req.operation)
         OP_INSERT: begin
            if (list_shadow.size() >= LIST_DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               list_shadow.push_front(req.key_value);
            end
         end
         OP_DELETE: begin
            if (hit < 0) begin
               outcome.status = STATUS_NOMATCH;
            end else begin
               list_shadow.delete(hit);
            end
         end
         OP_SEARCH: begin
            if (hit < 0) begin
               outcome.status = STATUS_NOMATCH;
            end
         end
         default: begin
            if (hit < 0) begin
               outcome.status = STATUS_NOMATCH;
            end else begin
               list_shadow[hit] = req.replacement;
            end
         end
      endcase
      outcome.entry_count = entry_count_type'(list_shadow.size());
      awaited_outcomes.push_back(outcome);
   endfunction

   function automatic void queue_request(input op_type op, input value_type key,
                                         input value_type repl, input bit drain);
      list_request_type req;
      req.operation   = op;
      req.key_value   = key;
      req.replacement = repl;
      req.drain_first = drain;
      pending_requests.push_back(req);
   endfunction

   // Driver: presents queued transactions, with random idle gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         // A transaction is taken when start is high and busy is low.
         if (presenting && !busy) begin
            predict_outcome(current_request);
            presenting = 1'b0;
            requests_accepted++;
            if (requests_accepted % 64 == 0) begin
               burst_mode = ($urandom_range(0, 2) == 0);
            end
            idle_left = burst_mode ? 0 : $urandom_range(0, 16);
         end
         // Load the next transaction once the gap has run out.
         if (!presenting) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           awaited_outcomes.size() != 0)) begin
               current_request = pending_requests.pop_front();
               req_operation   <= current_request.operation;
               req_key_value   <= current_request.key_value;
               req_replacement <= current_request.replacement;
               presenting = 1'b1;
            end
         end
         start <= presenting;
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: result with none expected: status %0d, count %0d",
                     $time, rsp_status, rsp_entry_count);
            fail_count++;
         end else begin
            observed_expect = awaited_outcomes.pop_front();
            if (rsp_status !== observed_expect.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, observed_expect.status, rsp_status);
               fail_count++;
            end
            if (rsp_entry_count !== observed_expect.entry_count) begin
               $display("%0t: entry count mismatch: expected %0d, actual %0d",
                        $time, observed_expect.entry_count, rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: directed transactions first, then random phases.
   initial begin
      value_type key_pool[8];
      value_type key;
      value_type repl;
      int        random_queued;
      int        phase;
      int        pool_span;
      int        mode;
      int        roll;
      int        n;
      int        k;
      op_type    op;

      // Operations on an empty store find nothing.
      queue_request(OP_DELETE, 32'sd9, 32'sd0, 1'b0);
      queue_request(OP_SEARCH, 32'sd9, 32'sd0, 1'b0);
      queue_request(OP_MODIFY, 32'sd9, 32'sd1, 1'b0);
      // Extreme values and a duplicate pair.
      queue_request(OP_INSERT, 32'h8000_0000, 32'sd0, 1'b0);
      queue_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_request(OP_INSERT, 32'sd5, 32'sd0, 1'b0);
      queue_request(OP_INSERT, 32'sd5, 32'sd0, 1'b0);
      queue_request(OP_SEARCH, 32'h7FFF_FFFF, 32'sd0, 1'b0);
      // Only the duplicate nearest the head is modified, then the other deleted.
      queue_request(OP_MODIFY, 32'sd5, -32'sd1, 1'b0);
      queue_request(OP_DELETE, 32'sd5, 32'sd0, 1'b0);
      queue_request(OP_DELETE, 32'sd3, 32'sd0, 1'b0);
      queue_request(OP_SEARCH, 32'sd0, 32'sd0, 1'b0);
      // Fill the store, then try one insert too many.
      for (n = 0; n < 13; n++) begin
         queue_request(OP_INSERT, (n == 0) ? 32'sd0 : value_type'($urandom),
                       value_type'($urandom), 1'b0);
      end
      queue_request(OP_INSERT, 32'sd77, 32'sd0, 1'b0);
      // The oldest entry is the deepest walk, then a miss on the fifteen entries left.
      queue_request(OP_DELETE, 32'h8000_0000, 32'sd0, 1'b0);
      queue_request(OP_MODIFY, 32'sd3, 32'sd4, 1'b0);

      // Random phases, each with its own key pool and operation mix.
      random_queued = 0;
      phase = 0;
      while (random_queued < RANDOM_ITEMS) begin
         for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 9))
               0:       key_pool[k] = 32'h8000_0000;
               1:       key_pool[k] = 32'h7FFF_FFFF;
               2:       key_pool[k] = 32'sd0;
               3:       key_pool[k] = -32'sd1;
               default: key_pool[k] = value_type'($urandom);
            endcase
         end
         pool_span = $urandom_range(2, 8);
         mode = $urandom_range(0, 2);
         for (n = 0; n < 60; n++) begin
            roll = $urandom_range(0, 99);
            // Mode 0 leans to filling, mode 1 to emptying, mode 2 is balanced.
            case (mode)
               0:       op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                             (roll < 90) ? OP_SEARCH : OP_MODIFY;
               1:       op = (roll < 20) ? OP_INSERT : (roll < 75) ? OP_DELETE :
                             (roll < 88) ? OP_SEARCH : OP_MODIFY;
               default: op = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_DELETE :
                             (roll < 78) ? OP_SEARCH : OP_MODIFY;
            endcase
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_span - 1)]
                                             : value_type'($urandom);
            repl = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, pool_span - 1)]
                                               : value_type'($urandom);
            // Now and then the sender holds off until the block has gone quiet.
            queue_request(op, key, repl, (n == 0) && (phase % 5 == 0));
            random_queued++;
         end
         phase++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every transaction to be taken and every result to arrive.
      while (pending_requests.size() != 0 || presenting || awaited_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/ovle_pkg.sv
src/ordered_value_list_engine.sv
dv/testbench.sv
